// ===== design/cst_pkg.sv =====
// coordinate set table: shared constants, codes and types
// used by the interfaces, the controller, the datapath and the top level
`default_nettype none

package cst_pkg;

  localparam int CAPACITY   = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int FUNC_W     = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_QUERY  = 3'd0,
    FUNC_INSERT = 3'd1,
    FUNC_REMOVE = 3'd2,
    FUNC_TOGGLE = 3'd3,
    FUNC_CLEAR  = 3'd4,
    FUNC_BBOX   = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY
  } state_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    coord_t            pos_x;
    coord_t            pos_y;
  } req_t;

  typedef struct packed {
    logic             was_present;
    logic             table_full;
    logic             set_empty;
    logic [CNT_W-1:0] entry_total;
    coord_t           box_min_x;
    coord_t           box_min_y;
    coord_t           box_max_x;
    coord_t           box_max_y;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic apply;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_slot;
  } status_t;

endpackage

`default_nettype wire

// ===== design/cst_req_if.sv =====
// request channel of the coordinate set table: valid/ready plus the request fields
// depends on cst_pkg
`default_nettype none

interface cst_req_if;
  import cst_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  coord_t            pos_x;
  coord_t            pos_y;

  modport source (output valid, output func, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input func, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

// ===== design/cst_rsp_if.sv =====
// result channel of the coordinate set table: valid/ready plus the result fields
// depends on cst_pkg
`default_nettype none

interface cst_rsp_if;
  import cst_pkg::*;

  logic             valid;
  logic             ready;
  logic             was_present;
  logic             table_full;
  logic             set_empty;
  logic [CNT_W-1:0] entry_total;
  coord_t           box_min_x;
  coord_t           box_min_y;
  coord_t           box_max_x;
  coord_t           box_max_y;

  modport source (
    output valid, output was_present, output table_full, output set_empty,
    output entry_total, output box_min_x, output box_min_y, output box_max_x,
    output box_max_y, input ready
  );
  modport sink (
    input valid, input was_present, input table_full, input set_empty,
    input entry_total, input box_min_x, input box_min_y, input box_max_x,
    input box_max_y, output ready
  );
endinterface

`default_nettype wire

// ===== design/cst_ctrl.sv =====
// coordinate set table controller: request handshake, slot scan sequencing,
// result register handshake; depends on cst_pkg
`default_nettype none

module cst_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire cst_pkg::status_t status_i,
  output cst_pkg::cmd_t         cmd_o
);
  import cst_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.last_slot) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_APPLY: begin
        cmd_o.apply = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // result register stays full until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.apply) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/cst_dp.sv =====
// coordinate set table datapath: slot memories, valid bits, entry count,
// one-slot-per-cycle match / free / bounding box scan, result register; depends on cst_pkg
`default_nettype none

module cst_dp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cst_pkg::cmd_t   cmd_i,
  output cst_pkg::status_t     status_o,
  input  wire cst_pkg::req_t   req_i,
  output cst_pkg::rsp_t        rsp_o
);
  import cst_pkg::*;

  coord_t mem_x [CAPACITY];
  coord_t mem_y [CAPACITY];

  logic [CAPACITY-1:0] valid_q;
  logic [CAPACITY-1:0] valid_d;
  logic [CNT_W-1:0]    count_q, count_d;

  req_t             req_q;
  logic [IDX_W-1:0] scan_idx_q;

  // read stage
  logic             rd_live_q;
  logic             rd_valid_q;
  logic [IDX_W-1:0] rd_idx_q;
  coord_t           rd_x_q;
  coord_t           rd_y_q;

  // scan trackers
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic             free_found_q;
  logic [IDX_W-1:0] free_idx_q;
  logic             any_q;
  coord_t           mnx_q, mny_q, mxx_q, mxy_q;

  rsp_t rsp_q;

  logic do_ins, do_rem, do_clr, full, ins_want, is_bbox;

  assign status_o.last_slot = (scan_idx_q == IDX_W'(CAPACITY - 1));

  // slot memories: written on insert, read one slot a cycle during the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && do_ins) begin
      mem_x[free_idx_q] <= req_q.pos_x;
      mem_y[free_idx_q] <= req_q.pos_y;
    end
    if (cmd_i.scan) begin
      rd_x_q <= mem_x[scan_idx_q];
      rd_y_q <= mem_y[scan_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      rd_live_q  <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_idx_q   <= '0;
    end else begin
      rd_live_q <= cmd_i.scan;
      if (cmd_i.start) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
        rd_valid_q <= valid_q[scan_idx_q];
        rd_idx_q   <= scan_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q.func  <= req_i.func;
      req_q.pos_x <= req_i.pos_x;
      req_q.pos_y <= req_i.pos_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      any_q        <= 1'b0;
    end else if (cmd_i.start) begin
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      any_q        <= 1'b0;
    end else if (rd_live_q) begin
      if (rd_valid_q && rd_x_q == req_q.pos_x && rd_y_q == req_q.pos_y) begin
        hit_q     <= 1'b1;
        hit_idx_q <= rd_idx_q;
      end
      // lowest free slot wins
      if (!rd_valid_q && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= rd_idx_q;
      end
      if (rd_valid_q) any_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_live_q && rd_valid_q) begin
      if (!any_q) begin
        mnx_q <= rd_x_q;
        mxx_q <= rd_x_q;
        mny_q <= rd_y_q;
        mxy_q <= rd_y_q;
      end else begin
        if (rd_x_q < mnx_q) mnx_q <= rd_x_q;
        if (rd_x_q > mxx_q) mxx_q <= rd_x_q;
        if (rd_y_q < mny_q) mny_q <= rd_y_q;
        if (rd_y_q > mxy_q) mxy_q <= rd_y_q;
      end
    end
  end

  // update decision once the scan is complete
  always_comb begin
    ins_want = 1'b0;
    do_rem   = 1'b0;
    do_clr   = 1'b0;
    is_bbox  = 1'b0;
    case (req_q.func)
      FUNC_INSERT: ins_want = 1'b1;
      FUNC_REMOVE: do_rem   = hit_q;
      FUNC_TOGGLE: begin
        ins_want = !hit_q;
        do_rem   = hit_q;
      end
      FUNC_CLEAR:  do_clr  = 1'b1;
      FUNC_BBOX:   is_bbox = 1'b1;
      default:     ins_want = 1'b0;
    endcase
    do_ins = ins_want && !hit_q && free_found_q;
    full   = ins_want && !hit_q && !free_found_q;
  end

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    if (do_clr) begin
      valid_d = '0;
      count_d = '0;
    end else if (do_ins) begin
      valid_d[free_idx_q] = 1'b1;
      count_d             = count_q + CNT_W'(1);
    end else if (do_rem) begin
      valid_d[hit_idx_q] = 1'b0;
      count_d            = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (cmd_i.apply) begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      rsp_q.was_present <= hit_q;
      rsp_q.table_full  <= full;
      rsp_q.set_empty   <= (count_d == '0);
      rsp_q.entry_total <= count_d;
      if (is_bbox && any_q) begin
        rsp_q.box_min_x <= mnx_q;
        rsp_q.box_min_y <= mny_q;
        rsp_q.box_max_x <= mxx_q;
        rsp_q.box_max_y <= mxy_q;
      end else begin
        rsp_q.box_min_x <= '0;
        rsp_q.box_min_y <= '0;
        rsp_q.box_max_x <= '0;
        rsp_q.box_max_y <= '0;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== design/coordinate_set_table.sv =====
// Coordinate set table: a set of up to 64 signed 16-bit (x, y) pairs.
// Requests arrive on req_i (func, pos_x, pos_y): query, insert, remove,
// toggle, clear all, bounding box. Each request produces exactly one result
// on rsp_o: was_present, table_full, set_empty, entry_total and, for a
// bounding box request, the min/max x and y (zero otherwise or when empty).
// Every request scans all 64 slots through one comparator, one slot per
// cycle out of the coordinate memory, then takes one read drain step and
// one update step; a new request is accepted only once the last one has
// left its update step and the block is back in idle.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the following request holds in its
// update step until the register is taken, and no request is accepted meanwhile.
// Reset clears all slot valid bits and the entry count; the block is ready
// in the first cycle after reset. Coordinate memory needs no clearing pass.
// Depends on cst_pkg, cst_req_if, cst_rsp_if, cst_ctrl and cst_dp.
`default_nettype none

module coordinate_set_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cst_req_if.sink   req_i,
  cst_rsp_if.source rsp_o
);
  import cst_pkg::*;

  cmd_t    cmd;
  status_t status;
  req_t    req;
  rsp_t    rsp;

  assign req.func  = req_i.func;
  assign req.pos_x = req_i.pos_x;
  assign req.pos_y = req_i.pos_y;

  cst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cst_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .req_i    (req),
    .rsp_o    (rsp)
  );

  assign rsp_o.was_present = rsp.was_present;
  assign rsp_o.table_full  = rsp.table_full;
  assign rsp_o.set_empty   = rsp.set_empty;
  assign rsp_o.entry_total = rsp.entry_total;
  assign rsp_o.box_min_x   = rsp.box_min_x;
  assign rsp_o.box_min_y   = rsp.box_min_y;
  assign rsp_o.box_max_x   = rsp.box_max_x;
  assign rsp_o.box_max_y   = rsp.box_max_y;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while a scan was already running");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.entry_total <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.table_full |->
      !rsp_o.was_present && rsp_o.entry_total == CNT_W'(CAPACITY))
    else $error("dropped insert with free slots or a present coordinate");

  a_empty_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.set_empty == (rsp_o.entry_total == '0))
    else $error("empty flag disagrees with entry count");

endmodule

`default_nettype wire

// ===== tb/coordinate_set_table_checker.sv =====
// checker for the coordinate set table: watches both channels, keeps its own copy
// of the set, predicts each result and compares it field by field
// depends on cst_pkg, cst_req_if and cst_rsp_if
`timescale 1ns / 1ps

module coordinate_set_table_checker (
  input  logic clk_i,
  input  logic rst_ni,
  cst_req_if   req_mon,
  cst_rsp_if   rsp_mon,
  output int   err_count,
  output int   pending,
  output int   checked,
  output int   dropped
);
  import cst_pkg::*;

  logic   slot_used [CAPACITY];
  coord_t slot_px   [CAPACITY];
  coord_t slot_py   [CAPACITY];
  int     set_size;
  rsp_t   expected_rsp_q [$];

  task automatic report(input string field, input logic [15:0] got, input logic [15:0] want);
    err_count++;
    if (err_count <= 100) begin
      $display("%0t mismatch on %s: got %h, expected %h", $time, field, got, want);
    end
  endtask

  // updates the set for one request and returns the result it should give
  function automatic rsp_t apply_request(input logic [FUNC_W-1:0] f, input coord_t x,
                                         input coord_t y);
    rsp_t   r;
    int     hit;
    int     free_idx;
    logic   first;
    coord_t mnx, mny, mxx, mxy;
    r = '0;
    hit = -1;
    free_idx = -1;
    first = 1'b1;
    mnx = '0;
    mny = '0;
    mxx = '0;
    mxy = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit < 0 && slot_used[i] && slot_px[i] == x && slot_py[i] == y) hit = i;
      if (free_idx < 0 && !slot_used[i]) free_idx = i;
    end
    case (f)
      FUNC_INSERT, FUNC_TOGGLE: begin
        if (hit < 0) begin
          if (free_idx < 0) begin
            r.table_full = 1'b1;
          end else begin
            slot_used[free_idx] = 1'b1;
            slot_px[free_idx] = x;
            slot_py[free_idx] = y;
            set_size++;
          end
        end else if (f == FUNC_TOGGLE) begin
          slot_used[hit] = 1'b0;
          set_size--;
        end
      end
      FUNC_REMOVE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          set_size--;
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
        set_size = 0;
      end
      FUNC_BBOX: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot_used[i]) begin
            if (first) begin
              mnx = slot_px[i];
              mxx = slot_px[i];
              mny = slot_py[i];
              mxy = slot_py[i];
              first = 1'b0;
            end else begin
              if (slot_px[i] < mnx) mnx = slot_px[i];
              if (slot_px[i] > mxx) mxx = slot_px[i];
              if (slot_py[i] < mny) mny = slot_py[i];
              if (slot_py[i] > mxy) mxy = slot_py[i];
            end
          end
        end
      end
      default: ;
    endcase
    r.was_present = (hit >= 0);
    r.set_empty   = (set_size == 0);
    r.entry_total = CNT_W'(set_size);
    r.box_min_x   = mnx;
    r.box_min_y   = mny;
    r.box_max_x   = mxx;
    r.box_max_y   = mxy;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
      set_size = 0;
      expected_rsp_q.delete();
      pending <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        expected_rsp_q.push_back(apply_request(req_mon.func, req_mon.pos_x, req_mon.pos_y));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        checked++;
        if (expected_rsp_q.size() == 0) begin
          report("result with no request outstanding", 16'h0, 16'h0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (want.table_full) dropped++;
          if (rsp_mon.was_present !== want.was_present)
            report("was_present", 16'(rsp_mon.was_present), 16'(want.was_present));
          if (rsp_mon.table_full !== want.table_full)
            report("table_full", 16'(rsp_mon.table_full), 16'(want.table_full));
          if (rsp_mon.set_empty !== want.set_empty)
            report("set_empty", 16'(rsp_mon.set_empty), 16'(want.set_empty));
          if (rsp_mon.entry_total !== want.entry_total)
            report("entry_total", 16'(rsp_mon.entry_total), 16'(want.entry_total));
          if (rsp_mon.box_min_x !== want.box_min_x)
            report("box_min_x", rsp_mon.box_min_x, want.box_min_x);
          if (rsp_mon.box_min_y !== want.box_min_y)
            report("box_min_y", rsp_mon.box_min_y, want.box_min_y);
          if (rsp_mon.box_max_x !== want.box_max_x)
            report("box_max_x", rsp_mon.box_max_x, want.box_max_x);
          if (rsp_mon.box_max_y !== want.box_max_y)
            report("box_max_y", rsp_mon.box_max_y, want.box_max_y);
        end
      end
      pending <= expected_rsp_q.size();
    end
  end

endmodule

// ===== tb/coordinate_set_table_test.sv =====
// top of the coordinate set table testbench: clock, reset, request stimulus and
// result-side stalls; the checker beside the block does the comparing
// depends on cst_pkg, the channel interfaces, coordinate_set_table and its checker
`timescale 1ns / 1ps

module coordinate_set_table_test;
  import cst_pkg::*;

  localparam int ITEMS        = 1850;
  localparam int TAIL_ITEMS   = 150;
  localparam int POOL_SIZE    = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_NOISE} mix_e;

  logic   clk_i   = 1'b0;
  logic   rst_ni  = 1'b0;
  logic   idle_on = 1'b1;
  int     stall_left;
  int     quiet_cycles;
  int     sent;
  int     op_sent [8];
  int     err_count, pending, checked, dropped;
  coord_t pool_x [POOL_SIZE];
  coord_t pool_y [POOL_SIZE];

  cst_req_if req_if ();
  cst_rsp_if rsp_if ();

  coordinate_set_table dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  coordinate_set_table_checker u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_mon  (req_if),
    .rsp_mon  (rsp_if),
    .err_count(err_count),
    .pending  (pending),
    .checked  (checked),
    .dropped  (dropped)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: random stall bursts while idling is on
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (idle_on && stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 12);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("no request or result moved for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input logic [FUNC_W-1:0] f, input coord_t x, input coord_t y);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= f;
    req_if.pos_x <= x;
    req_if.pos_y <= y;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    op_sent[f]++;
    sent++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    mix_e              mix;
    int                run_len, roll, k, round;
    logic [FUNC_W-1:0] f;
    coord_t            x, y;

    req_if.valid = 1'b0;
    req_if.func  = FUNC_QUERY;
    req_if.pos_x = '0;
    req_if.pos_y = '0;
    rsp_if.ready = 1'b0;

    // small pool so that hits, removals and a full table come up often
    pool_x[0] = 16'sh8000; pool_y[0] = 16'sh8000;
    pool_x[1] = 16'sh7fff; pool_y[1] = 16'sh7fff;
    pool_x[2] = 16'sh8000; pool_y[2] = 16'sh7fff;
    pool_x[3] = 16'sh7fff; pool_y[3] = 16'sh8000;
    pool_x[4] = 16'sh0000; pool_y[4] = 16'sh0000;
    pool_x[5] = 16'shffff; pool_y[5] = 16'shffff;
    for (int i = 6; i < POOL_SIZE; i++) begin
      pool_x[i] = coord_t'($urandom);
      pool_y[i] = coord_t'($urandom);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty box, absent coordinates, extremes, duplicates, toggles,
    // spare selectors and clear with the coordinate present and absent
    send_req(FUNC_BBOX,     16'sh0000, 16'sh0000);
    send_req(FUNC_QUERY,    16'sh0000, 16'sh0000);
    send_req(FUNC_REMOVE,   16'sh0005, 16'sh0005);
    send_req(FUNC_INSERT,   16'sh8000, 16'sh8000);
    send_req(FUNC_INSERT,   16'sh7fff, 16'sh7fff);
    send_req(FUNC_INSERT,   16'sh7fff, 16'sh7fff);
    send_req(FUNC_INSERT,   16'shffff, 16'sh0000);
    send_req(FUNC_QUERY,    16'shffff, 16'sh0000);
    send_req(FUNC_BBOX,     16'sh1234, 16'sh4321);
    send_req(FUNC_TOGGLE,   16'sh0064, 16'shff9c);
    send_req(FUNC_TOGGLE,   16'sh0064, 16'shff9c);
    send_req(FUNC_REMOVE,   16'shffff, 16'sh0000);
    send_req(FUNC_SPARE_LO, 16'sh7fff, 16'sh7fff);
    send_req(FUNC_SPARE_HI, 16'sh0001, 16'sh0001);
    send_req(FUNC_CLEAR,    16'sh8000, 16'sh8000);
    send_req(FUNC_BBOX,     16'sh7fff, 16'sh8000);
    send_req(FUNC_INSERT,   16'sh0000, 16'sh8000);
    send_req(FUNC_INSERT,   16'sh8000, 16'sh7fff);
    send_req(FUNC_INSERT,   16'sh5555, 16'shaaaa);
    send_req(FUNC_BBOX,     16'sh0000, 16'sh0000);
    send_req(FUNC_CLEAR,    16'sh0123, 16'sh0456);
    send_req(FUNC_QUERY,    16'sh0000, 16'sh8000);

    round = 0;
    while (sent < ITEMS) begin
      roll = $urandom_range(0, 9);
      mix = mix_e'(roll < 4 ? MIX_FILL : roll < 7 ? MIX_CHURN : roll < 9 ? MIX_DRAIN :
                   MIX_NOISE);
      idle_on = (sent < ITEMS - TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
      // hold off until every outstanding request has been answered
      if (round == 3 || $urandom_range(0, 11) == 0) wait_drained();
      round++;
      run_len = $urandom_range(20, 120);
      for (int n = 0; n < run_len && sent < ITEMS; n++) begin
        if (sent >= ITEMS - TAIL_ITEMS) idle_on = 1'b0;
        roll = $urandom_range(0, 99);
        case (mix)
          MIX_FILL: begin
            f = roll < 70 ? FUNC_INSERT : roll < 80 ? FUNC_TOGGLE :
                roll < 90 ? FUNC_QUERY : FUNC_BBOX;
          end
          MIX_CHURN: begin
            f = roll < 25 ? FUNC_INSERT : roll < 50 ? FUNC_REMOVE :
                roll < 70 ? FUNC_TOGGLE : roll < 85 ? FUNC_QUERY :
                roll < 97 ? FUNC_BBOX : FUNC_CLEAR;
          end
          MIX_DRAIN: begin
            f = roll < 60 ? FUNC_REMOVE : roll < 75 ? FUNC_TOGGLE :
                roll < 90 ? FUNC_BBOX : FUNC_QUERY;
          end
          default: f = FUNC_W'($urandom);
        endcase
        k = $urandom_range(0, POOL_SIZE - 1);
        if (mix != MIX_NOISE && $urandom_range(0, 99) < 85) begin
          x = pool_x[k];
          y = pool_y[k];
        end else begin
          x = coord_t'($urandom);
          y = coord_t'($urandom);
        end
        send_req(f, x, y);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d requests: %0d query, %0d insert, %0d remove, %0d toggle, %0d clear,",
             sent, op_sent[FUNC_QUERY], op_sent[FUNC_INSERT], op_sent[FUNC_REMOVE],
             op_sent[FUNC_TOGGLE], op_sent[FUNC_CLEAR]);
    $display("%0d box, %0d spare selector; %0d results compared, %0d inserts dropped when full",
             op_sent[FUNC_BBOX], op_sent[FUNC_SPARE_LO] + op_sent[FUNC_SPARE_HI],
             checked, dropped);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/cst_pkg.sv
design/cst_req_if.sv
design/cst_rsp_if.sv
design/cst_ctrl.sv
design/cst_dp.sv
design/coordinate_set_table.sv
tb/coordinate_set_table_checker.sv
tb/coordinate_set_table_test.sv
